// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define GRR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define GRR_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GRR_ASSERT(label, clk, rst_n, prop, msg)
`define GRR_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph row rasterizer package
// Shared constants, register indexes and interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

  localparam int FONT_BYTES  = 16384;
  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 32;

  localparam int ADDR_W  = $clog2(FONT_BYTES);
  localparam int CFG_W   = 6;                      // height / columns register width
  localparam int COLOR_W = 16;
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int REG_IDX_W = 2;

  localparam logic [CODE_W-1:0] FIRST_CODE = CODE_W'(32);
  localparam logic [CODE_W-1:0] LAST_CODE  = CODE_W'(127);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GLYPH_HEIGHT  = 2'd0,
    REG_GLYPH_COLUMNS = 2'd1,
    REG_TEXT_COLOR    = 2'd2,
    REG_BACK_COLOR    = 2'd3
  } grr_reg_e;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } grr_cmd_e;

  typedef struct packed {
    logic [CFG_W-1:0]   glyph_height;
    logic [CFG_W-1:0]   glyph_columns;
    logic [COLOR_W-1:0] text_color;
    logic [COLOR_W-1:0] back_color;
  } grr_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } grr_mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/glyph_row_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// Glyph row rasterizer
// Column-major bitmap font store and single glyph row pixel generator.
// ----------------------------------------------------------------------------
// A font write transaction leaves the sequencer idle, so the block stays
// ready for the next transaction. A render transaction that produces
// pixels runs the record multiply, the base multiply, the width byte read
// and the width check, then one font byte read and one pixel per column,
// and it waits while the output side stalls; the single read port of the
// font memory sets the one-pixel-per-cycle pace. A render that falls
// outside the glyph finishes in the accept cycle or after the width check.
// The output register lets the next transaction be accepted while the last
// pixel still waits. Configuration writes are accepted every cycle.
`default_nettype none

module glyph_row_rasterizer_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [grr_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [grr_pkg::COLOR_W-1:0]     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            command_i,
  input  wire logic [grr_pkg::ADDR_W-1:0]      font_address_i,
  input  wire logic [grr_pkg::BYTE_W-1:0]      font_byte_i,
  input  wire logic [grr_pkg::CODE_W-1:0]      char_code_i,
  input  wire logic [grr_pkg::ROW_W-1:0]       row_index_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [grr_pkg::COLOR_W-1:0]          pixel_color_o,
  output logic [grr_pkg::COL_W-1:0]            column_index_o,
  output logic                                 last_pixel_o
);
  import grr_pkg::*;

  grr_cfg_t          cfg_q, cfg_d;
  grr_mem_req_t      mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (grr_reg_e'(cfg_index_i))
        REG_GLYPH_HEIGHT:  cfg_d.glyph_height  = cfg_data_i[CFG_W-1:0];
        REG_GLYPH_COLUMNS: cfg_d.glyph_columns = cfg_data_i[CFG_W-1:0];
        REG_TEXT_COLOR:    cfg_d.text_color    = cfg_data_i;
        REG_BACK_COLOR:    cfg_d.back_color    = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_height  <= CFG_W'(8);
      cfg_q.glyph_columns <= CFG_W'(8);
      cfg_q.text_color    <= '1;
      cfg_q.back_color    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  grr_font_mem u_font_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  grr_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .font_address_i (font_address_i),
    .font_byte_i    (font_byte_i),
    .char_code_i    (char_code_i),
    .row_index_i    (row_index_i),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_color_o  (pixel_color_o),
    .column_index_o (column_index_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

`default_nettype wire

// ===== rtl/grr_font_mem.sv =====
// ----------------------------------------------------------------------------
// Font memory
// Byte-wide single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_font_mem (
  input  wire logic                         clk_i,
  input  wire grr_pkg::grr_mem_req_t        req_i,
  output logic [grr_pkg::BYTE_W-1:0]        rdata_o
);
  import grr_pkg::*;

  logic [BYTE_W-1:0] mem [FONT_BYTES];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[req_i.raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/grr_seq.sv =====
// ----------------------------------------------------------------------------
// Glyph row sequencer
// Decodes commands, forms record addresses and walks glyph columns with one
// shared address adder, one font byte and one pixel per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grr_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire grr_pkg::grr_cfg_t             cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          command_i,
  input  wire logic [grr_pkg::ADDR_W-1:0]    font_address_i,
  input  wire logic [grr_pkg::BYTE_W-1:0]    font_byte_i,
  input  wire logic [grr_pkg::CODE_W-1:0]    char_code_i,
  input  wire logic [grr_pkg::ROW_W-1:0]     row_index_i,
  output grr_pkg::grr_mem_req_t              mem_req_o,
  input  wire logic [grr_pkg::BYTE_W-1:0]    mem_rdata_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [grr_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic [grr_pkg::COL_W-1:0]          column_index_o,
  output logic                               last_pixel_o
);
  import grr_pkg::*;

  localparam int BR_W   = 3;                 // bytes per column, 0..4
  localparam int REC_W  = CFG_W + BR_W;      // record size
  localparam int OFF_W  = 7;                 // code offset, 0..95
  localparam int PROD_W = OFF_W + REC_W;
  localparam int WID_W  = CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_REC,
    S_MUL_BASE,
    S_WID_RD,
    S_WID_CHK,
    S_COLS
  } state_e;

  state_e             state_q, state_d;
  logic [OFF_W-1:0]   code_off_q, code_off_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [REC_W-1:0]   record_q, record_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [ADDR_W-1:0]  ptr_q;
  logic [WID_W-1:0]   width_q, width_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] pixel_q, pixel_d;
  logic [COL_W-1:0]   out_col_q, out_col_d;
  logic               last_q, last_d;

  logic [CFG_W-1:0]   height;
  logic [CFG_W:0]     height_rnd;
  logic [BR_W-1:0]    byte_rows;
  logic [CFG_W-1:0]   col_limit;
  logic [CODE_W-1:0]  code_diff;
  logic [PROD_W-1:0]  base_prod;
  logic [ADDR_W-1:0]  add_a, add_b, rd_addr;
  logic               accept, render_ok, fire, is_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == S_COLS) && (!out_valid_q || out_ready_i);
  assign is_last    = ({1'b0, col_q} == (width_q - WID_W'(1)));

  always_comb begin
    height     = (cfg_i.glyph_height > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS)
                                                          : cfg_i.glyph_height;
    height_rnd = {1'b0, height} + (CFG_W + 1)'(7);
    byte_rows  = height_rnd[BR_W+2:3];
    col_limit  = (cfg_i.glyph_columns > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS)
                                                              : cfg_i.glyph_columns;
    code_diff  = char_code_i - FIRST_CODE;
    render_ok  = (char_code_i >= FIRST_CODE) && (char_code_i <= LAST_CODE) &&
                 ({1'b0, row_index_i} < height);
    base_prod  = {{REC_W{1'b0}}, code_off_q} * {{OFF_W{1'b0}}, record_q};
  end

  // shared address adder: record base, first column byte, column stride
  always_comb begin
    add_a = ptr_q;
    add_b = '0;
    case (state_q)
      S_WID_RD: begin
        add_a = base_q;
      end
      S_WID_CHK: begin
        add_a = base_q;
        add_b = ADDR_W'(1) + ADDR_W'(row_q[ROW_W-1:3]);
      end
      S_COLS: begin
        add_b = fire ? ADDR_W'(byte_rows) : '0;
      end
      default: begin
        add_a = ptr_q;
      end
    endcase
    rd_addr = add_a + add_b;
  end

  always_comb begin
    mem_req_o.we    = accept && (command_i == CMD_WRITE);
    mem_req_o.waddr = font_address_i;
    mem_req_o.wdata = font_byte_i;
    mem_req_o.raddr = rd_addr;
  end

  always_comb begin
    state_d     = state_q;
    code_off_d  = code_off_q;
    row_d       = row_q;
    record_d    = record_q;
    base_d      = base_q;
    width_d     = width_q;
    col_d       = col_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pixel_d     = pixel_q;
    out_col_d   = out_col_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (command_i == CMD_RENDER) && render_ok) begin
          code_off_d = code_diff[OFF_W-1:0];
          row_d      = row_index_i;
          state_d    = S_MUL_REC;
        end
      end
      S_MUL_REC: begin
        record_d = REC_W'(cfg_i.glyph_columns) * REC_W'(byte_rows) + REC_W'(1);
        state_d  = S_MUL_BASE;
      end
      S_MUL_BASE: begin
        base_d  = base_prod[ADDR_W-1:0];   // wraps modulo memory size
        state_d = S_WID_RD;
      end
      S_WID_RD: begin
        state_d = S_WID_CHK;
      end
      S_WID_CHK: begin
        width_d = (mem_rdata_i > {2'b00, col_limit}) ? col_limit : mem_rdata_i[WID_W-1:0];
        col_d   = '0;
        state_d = (width_d == '0) ? S_IDLE : S_COLS;
      end
      S_COLS: begin
        if (fire) begin
          out_valid_d = 1'b1;
          pixel_d     = mem_rdata_i[row_q[2:0]] ? cfg_i.text_color : cfg_i.back_color;
          out_col_d   = col_q;
          last_d      = is_last;
          col_d       = col_q + COL_W'(1);
          if (is_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      code_off_q  <= '0;
      row_q       <= '0;
      record_q    <= '0;
      base_q      <= '0;
      ptr_q       <= '0;
      width_q     <= '0;
      col_q       <= '0;
      pixel_q     <= '0;
      out_col_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      code_off_q  <= code_off_d;
      row_q       <= row_d;
      record_q    <= record_d;
      base_q      <= base_d;
      ptr_q       <= rd_addr;     // read data always belongs to ptr_q
      width_q     <= width_d;
      col_q       <= col_d;
      pixel_q     <= pixel_d;
      out_col_q   <= out_col_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_color_o  = pixel_q;
  assign column_index_o = out_col_q;
  assign last_pixel_o   = last_q;

  `GRR_ASSERT(a_last_ends_row, clk_i, rst_ni, (fire && is_last) |=> in_ready_o, "last pixel did not end row")
  `GRR_ASSERT(a_col_in_width, clk_i, rst_ni, fire |-> ({1'b0, col_q} < width_q), "column beyond width")
  `GRR_ASSERT(a_render_busy, clk_i, rst_ni, (accept && command_i == CMD_RENDER && render_ok) |=> !in_ready_o, "render did not start")
  `GRR_ASSERT_NEVER(a_no_write_busy, clk_i, rst_ni, mem_req_o.we && (state_q != S_IDLE), "font write while busy")

endmodule

`default_nettype wire

// ===== bench/glyph_row_rasterizer_top_test.sv =====
// ----------------------------------------------------------------------------
// Glyph row rasterizer testbench
// Loads glyph records into the font store, then renders glyph rows under
// several register settings. Every accepted transaction updates a local font
// image and pixel predictor, and each pixel the block returns is checked in
// order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_rasterizer_top_test;
  import grr_pkg::*;

  localparam int DRAIN_CYCLES    = 12;        // covers a no-pixel render past its width check
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_PHASES   = 6;
  localparam int RENDERS_PER_PHASE = 22;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COL_W-1:0]   column;
    logic               last;
  } pixel_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 command;
  logic [ADDR_W-1:0]    font_address;
  logic [BYTE_W-1:0]    font_byte;
  logic [CODE_W-1:0]    char_code;
  logic [ROW_W-1:0]     row_index;
  logic                 out_valid;
  logic                 rx_ready;
  logic                 hold_off;
  logic                 out_ready;
  logic [COLOR_W-1:0]   pixel_color;
  logic [COL_W-1:0]     column_index;
  logic                 last_pixel;

  assign out_ready = rx_ready & ~hold_off;

  // local copy of the font store and registers
  logic [BYTE_W-1:0]  font_image [FONT_BYTES];
  logic [CFG_W-1:0]   height_reg;
  logic [CFG_W-1:0]   columns_reg;
  logic [COLOR_W-1:0] text_reg;
  logic [COLOR_W-1:0] back_reg;

  pixel_t expected_pixels[$];
  int     mismatches;
  bit     tx_idle;
  bit     rx_idle;

  glyph_row_rasterizer_top DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .font_address_i (font_address),
    .font_byte_i    (font_byte),
    .char_code_i    (char_code),
    .row_index_i    (row_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_color_o  (pixel_color),
    .column_index_o (column_index),
    .last_pixel_o   (last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned glyph_rows();
    return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
  endfunction

  function automatic int unsigned column_bytes();
    return (glyph_rows() + 7) / 8;
  endfunction

  function automatic int unsigned record_base(input logic [CODE_W-1:0] code);
    return (int'(code) - int'(FIRST_CODE)) * (int'(columns_reg) * column_bytes() + 1);
  endfunction

  function automatic void rasterize(input grr_cmd_e cmd, input logic [ADDR_W-1:0] addr,
                                    input logic [BYTE_W-1:0] data,
                                    input logic [CODE_W-1:0] code,
                                    input logic [ROW_W-1:0] row);
    int unsigned base;
    int unsigned width;
    int unsigned bits;
    pixel_t      px;
    if (cmd == CMD_WRITE) begin
      font_image[addr] = data;
      return;
    end
    if (code < FIRST_CODE || code > LAST_CODE || row >= glyph_rows()) return;
    base  = record_base(code);
    width = font_image[base % FONT_BYTES];
    if (width > columns_reg) width = columns_reg;
    if (width > MAX_COLUMNS) width = MAX_COLUMNS;
    for (int unsigned c = 0; c < width; c++) begin
      bits      = font_image[(base + 1 + c * column_bytes() + row / 8) % FONT_BYTES];
      px.color  = ((bits >> (row % 8)) & 1) ? text_reg : back_reg;
      px.column = COL_W'(c);
      px.last   = (c + 1 == width);
      expected_pixels.push_back(px);
    end
  endfunction

  task automatic issue_command(input grr_cmd_e cmd, input logic [ADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0] data,
                               input logic [CODE_W-1:0] code,
                               input logic [ROW_W-1:0] row);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command      = cmd;
    font_address = addr;
    font_byte    = data;
    char_code    = code;
    row_index    = row;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    rasterize(cmd, addr, data, code, row);
  endtask

  task automatic write_font(input int unsigned addr, input logic [BYTE_W-1:0] data);
    issue_command(CMD_WRITE, ADDR_W'(addr), data, CODE_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic render(input logic [CODE_W-1:0] code, input logic [ROW_W-1:0] row);
    issue_command(CMD_RENDER, ADDR_W'($urandom), BYTE_W'($urandom), code, row);
  endtask

  // wait until every predicted pixel is back and the block has gone quiet
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input grr_reg_e idx, input logic [COLOR_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GLYPH_HEIGHT:  height_reg  = value[CFG_W-1:0];
      REG_GLYPH_COLUMNS: columns_reg = value[CFG_W-1:0];
      REG_TEXT_COLOR:    text_reg    = value;
      REG_BACK_COLOR:    back_reg    = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // writes the width byte plus every column a render of this glyph reads
  task automatic load_glyph(input logic [CODE_W-1:0] code, input logic [BYTE_W-1:0] width,
                            input bit random_bits, input logic [BYTE_W-1:0] fixed);
    int unsigned base;
    int unsigned cols;
    base = record_base(code);
    cols = width;
    if (cols > columns_reg) cols = columns_reg;
    if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
    write_font(base % FONT_BYTES, width);
    for (int unsigned i = 0; i < cols * column_bytes(); i++)
      write_font((base + 1 + i) % FONT_BYTES, random_bits ? BYTE_W'($urandom) : fixed);
  endtask

  // reset register values, all code and row boundaries
  task automatic test_row_rendering();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_glyph(8'd32, 8'd8, 1'b0, 8'hFF);
    load_glyph(8'd127, 8'd255, 1'b0, 8'h00);
    load_glyph(8'd65, 8'd5, 1'b1, 8'h00);
    load_glyph(8'd66, 8'd0, 1'b1, 8'h00);
    render(8'd32, 5'd0);
    render(8'd127, 5'd7);
    render(8'd65, 5'd3);
    render(8'd65, 5'd0);
    render(8'd66, 5'd2);
    render(8'd31, 5'd0);
    render(8'd128, 5'd0);
    render(8'd0, 5'd0);
    render(8'd255, 5'd7);
    render(8'd65, 5'd8);
    render(8'd65, 5'd31);
  endtask

  task automatic test_register_extremes();
    write_register(REG_GLYPH_HEIGHT, 16'd32);
    write_register(REG_GLYPH_COLUMNS, 16'd32);
    write_register(REG_TEXT_COLOR, 16'h0000);
    write_register(REG_BACK_COLOR, 16'hFFFF);
    load_glyph(8'd127, 8'd5, 1'b1, 8'h00);
    load_glyph(8'd32, 8'd3, 1'b1, 8'h00);
    render(8'd127, 5'd0);
    render(8'd127, 5'd31);
    render(8'd32, 5'd17);
    render(8'd32, 5'd31);
    write_register(REG_TEXT_COLOR, 16'hFFFF);
    write_register(REG_BACK_COLOR, 16'h0000);
    write_register(REG_GLYPH_HEIGHT, 16'd1);
    write_register(REG_GLYPH_COLUMNS, 16'd1);
    load_glyph(8'd32, 8'd1, 1'b0, 8'h01);
    load_glyph(8'd127, 8'd1, 1'b0, 8'h00);
    render(8'd32, 5'd0);
    render(8'd127, 5'd0);
    render(8'd32, 5'd1);
    // zero height: nothing renders
    write_register(REG_GLYPH_HEIGHT, 16'd0);
    render(8'd32, 5'd0);
    // wide glyph clamps to 32 columns
    write_register(REG_GLYPH_HEIGHT, 16'd8);
    write_register(REG_GLYPH_COLUMNS, 16'd63);
    load_glyph(8'd100, 8'd40, 1'b1, 8'h00);
    render(8'd100, 5'd5);
    render(8'd100, 5'd7);
    // oversized height clamps to 32 rows, record base wraps
    write_register(REG_GLYPH_HEIGHT, 16'd63);
    load_glyph(8'd127, 8'd2, 1'b1, 8'h00);
    render(8'd127, 5'd31);
    render(8'd127, 5'd20);
    // only the low six bits of a geometry write count
    write_register(REG_GLYPH_HEIGHT, 16'hFFC8);
    write_register(REG_GLYPH_COLUMNS, 16'h0005);
    load_glyph(8'd65, 8'd9, 1'b1, 8'h00);
    render(8'd65, 5'd3);
  endtask

  // output held off long enough that the block backs up into its input
  task automatic test_backpressure();
    write_register(REG_GLYPH_HEIGHT, 16'd8);
    write_register(REG_GLYPH_COLUMNS, 16'd8);
    write_register(REG_TEXT_COLOR, COLOR_W'($urandom));
    write_register(REG_BACK_COLOR, COLOR_W'($urandom));
    load_glyph(8'd70, 8'd8, 1'b1, 8'h00);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    fork
      begin
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (24) render(8'd70, ROW_W'($urandom_range(0, 7)));
      end
    join
  endtask

  task automatic test_random_glyphs();
    logic [CODE_W-1:0] glyph_codes [2];
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_register(REG_GLYPH_HEIGHT, COLOR_W'(($urandom_range(0, 3) == 0) ?
                     $urandom_range(1, 32) : $urandom_range(1, 12)));
      write_register(REG_GLYPH_COLUMNS, COLOR_W'(($urandom_range(0, 3) == 0) ?
                     $urandom_range(1, 32) : $urandom_range(1, 12)));
      write_register(REG_TEXT_COLOR, COLOR_W'($urandom));
      write_register(REG_BACK_COLOR, COLOR_W'($urandom));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      foreach (glyph_codes[i]) begin
        glyph_codes[i] = CODE_W'($urandom_range(FIRST_CODE, LAST_CODE));
        load_glyph(glyph_codes[i], BYTE_W'($urandom_range(0, columns_reg + 2)), 1'b1, 8'h00);
      end
      repeat (RENDERS_PER_PHASE) begin
        if ($urandom_range(0, 4) != 0)
          render(glyph_codes[$urandom_range(0, 1)],
                 ROW_W'($urandom_range(0, glyph_rows() - 1)));
        else if ($urandom_range(0, 1) == 0)
          render(CODE_W'($urandom_range(0, 31)), ROW_W'($urandom_range(0, 31)));
        else
          render(CODE_W'($urandom_range(128, 255)), ROW_W'($urandom_range(0, 31)));
      end
    end
  endtask

  // pixel receiver and checker
  initial begin
    int     stall;
    pixel_t px;
    rx_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (stall > 0) begin
        rx_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rx_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: color %h col %0d last %b",
                   pixel_color, column_index, last_pixel);
      end else begin
        px = expected_pixels.pop_front();
        if (pixel_color !== px.color || column_index !== px.column || last_pixel !== px.last)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected color %h col %0d last %b, got %h %0d %b",
                     px.color, px.column, px.last, pixel_color, column_index, last_pixel);
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_GLYPH_HEIGHT;
    cfg_data     = '0;
    in_valid     = 1'b0;
    command      = CMD_WRITE;
    font_address = '0;
    font_byte    = '0;
    char_code    = '0;
    row_index    = '0;
    hold_off     = 1'b0;
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    mismatches   = 0;
    height_reg   = 6'd8;
    columns_reg  = 6'd8;
    text_reg     = 16'hFFFF;
    back_reg     = 16'h0000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_row_rendering();
    test_register_extremes();
    test_backpressure();
    test_random_glyphs();
    drain();

    if (mismatches == 0)
      $display("glyph_row_rasterizer_top test passed");
    else
      $display("glyph_row_rasterizer_top test failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("glyph_row_rasterizer_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
